[hdl/oaht_pkg.sv]
// package for the open addressing hash table: payload structs, codes, constants
// no dependencies
`timescale 1ns / 1ps
package oaht_pkg;
  localparam int CAPACITY_DEF = 256;
  localparam int FILL_W = 9;
  localparam logic [FILL_W-1:0] MAX_FILL_RST = 9'd192;

  localparam logic [1:0] MODE_GET = 2'd0;
  localparam logic [1:0] MODE_SET = 2'd1;
  localparam logic [1:0] MODE_DEL = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_LIVE = 2'd1;
  localparam logic [1:0] SLOT_TOMB = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key_id;
    logic [31:0] key_hash;
    logic [63:0] value_in;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        new_key;
    logic [63:0] value_out;
  } rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_READ, BK_CHECK, BK_VAL, BK_DONE, BK_CLEAR
  } bk_state_t;
endpackage

[hdl/oaht_ram.sv]
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module oaht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[hdl/oaht_front.sv]
// front: takes commands into a one-deep queue and computes the start slot
// depends on oaht_pkg
`timescale 1ns / 1ps
module oaht_front
  import oaht_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  req_t                        req,
  output logic                        busy,
  output logic                        q_valid,
  output req_t                        q_req,
  output logic [$clog2(CAPACITY)-1:0] q_idx,
  input  logic                        q_take
);
  localparam int AW = $clog2(CAPACITY);
  // power-of-two capacity: the start slot is the low hash bits
  assign busy = q_valid;
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (start && !busy) begin
      q_valid <= 1'b1;
    end else if (q_take) begin
      q_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      q_req <= req;
      q_idx <= req.key_hash[AW-1:0];
    end
  end
endmodule

[hdl/oaht_back.sv]
// back: probe sequencer over status, key and value rams
// depends on oaht_pkg, oaht_ram
`timescale 1ns / 1ps
module oaht_back
  import oaht_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [FILL_W-1:0]           max_fill,
  input  logic                        q_valid,
  input  req_t                        q_req,
  input  logic [$clog2(CAPACITY)-1:0] q_idx,
  output logic                        q_take,
  output logic                        done,
  output rsp_t                        rsp
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;

  bk_state_t state, state_next;
  logic [AW-1:0] idx, tomb_idx, addr;
  logic [CW-1:0] cnt;
  logic tomb_found;
  logic [FILL_W:0] fill;
  req_t cur;
  logic st_we, k_we, v_we;
  logic [1:0] st_wd, st_rd;
  logic [31:0] k_rd;
  logic [63:0] v_rd;
  logic [AW-1:0] clr;
  logic clr_last;
  logic empty_ok;

  oaht_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_st (
    .clk(clk), .we(st_we), .addr(addr), .wdata(st_wd), .rdata(st_rd));
  oaht_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_key (
    .clk(clk), .we(k_we), .addr(addr), .wdata(cur.key_id), .rdata(k_rd));
  oaht_ram #(.WIDTH(64), .DEPTH(CAPACITY)) u_val (
    .clk(clk), .we(v_we), .addr(addr), .wdata(cur.value_in), .rdata(v_rd));

  assign clr_last = (clr == AW'(CAPACITY - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
      clr <= '0;
      fill <= '0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr <= clr + 1'b1;
      end
      if (state == BK_CHECK && st_rd == SLOT_EMPTY && cur.mode == MODE_SET && !tomb_found
          && fill < {1'b0, max_fill}) begin
        fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          cur <= q_req;
          idx <= q_idx;
          cnt <= '0;
          tomb_found <= 1'b0;
        end
      end
      BK_CHECK: begin
        if (st_rd == SLOT_TOMB && !tomb_found) begin
          tomb_found <= 1'b1;
          tomb_idx <= idx;
        end
        if (!(st_rd == SLOT_EMPTY || (st_rd == SLOT_LIVE && k_rd == cur.key_id))) begin
          idx <= idx + 1'b1;
          cnt <= cnt + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    q_take = 1'b0;
    done = 1'b0;
    rsp = '{status: ST_MISSING, new_key: 1'b0, value_out: 64'd0};
    addr = idx;
    st_we = 1'b0;
    k_we = 1'b0;
    v_we = 1'b0;
    st_wd = SLOT_LIVE;
    case (state)
      BK_CLEAR: begin
        addr = clr;
        st_we = 1'b1;
        st_wd = SLOT_EMPTY;
        if (clr_last) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          state_next = BK_READ;
        end
      end
      BK_READ: state_next = BK_CHECK;
      BK_CHECK: begin
        if ((st_rd == SLOT_LIVE && k_rd == cur.key_id) || st_rd == SLOT_EMPTY
            || cnt == CW'(CAPACITY - 1)) begin
          // last probe: decide using this slot's flags
          state_next = BK_DONE;
          if (st_rd == SLOT_LIVE && k_rd == cur.key_id) begin
            state_next = BK_VAL;
          end else if (st_rd == SLOT_TOMB && !tomb_found) begin
            state_next = BK_DONE;
          end
        end else begin
          state_next = BK_READ;
        end
      end
      BK_VAL: begin
        // value ram read of the hit slot is now valid
        done = 1'b1;
        rsp.status = ST_DONE;
        state_next = BK_IDLE;
        case (cur.mode)
          MODE_GET: rsp.value_out = v_rd;
          MODE_SET: v_we = 1'b1;
          MODE_DEL: begin
            st_we = 1'b1;
            st_wd = SLOT_TOMB;
          end
          default: rsp.status = ST_MISSING;
        endcase
      end
      BK_DONE: begin
        // miss: idx sits at the empty slot, or back at the start slot after a full wrap
        done = 1'b1;
        state_next = BK_IDLE;
        if (cur.mode == MODE_SET) begin
          if (tomb_found) begin
            addr = tomb_idx;
            st_we = 1'b1;
            k_we = 1'b1;
            v_we = 1'b1;
            rsp.status = ST_DONE;
            rsp.new_key = 1'b1;
          end else if (empty_ok) begin
            st_we = 1'b1;
            k_we = 1'b1;
            v_we = 1'b1;
            rsp.status = ST_DONE;
            rsp.new_key = 1'b1;
          end else begin
            rsp.status = ST_FULL;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // empty slot reached and room left; fill already bumped in CHECK
  always_ff @(posedge clk) begin
    if (state == BK_CHECK) begin
      empty_ok <= (st_rd == SLOT_EMPTY) && (fill < {1'b0, max_fill});
    end
  end
endmodule

[hdl/open_addressing_hash_table.sv]
// top level of the open addressing hash table
// depends on oaht_pkg, oaht_front, oaht_back, oaht_ram
`timescale 1ns / 1ps
// usage
// - command channel: start with req (mode, key_id, key_hash, value_in) transfers
//   at an edge where busy is low; one queue slot decouples front from back
// - result channel: done strobes one cycle with rsp (status, new_key, value_out);
//   the receiver cannot stall, so no backpressure exists
// - config: cfg_we writes max_fill from cfg_data at any edge, block idle
// - probing: each probed slot passes a READ state (status and key ram read) and a CHECK
//   state; a command queues in the front first, then a hit ends in VAL and a miss in DONE
// - the back handles one command at a time; the front queue holds one more
// - reset: a clearing pass marks all CAPACITY slots empty, one a cycle; commands
//   queue once but wait until it ends
// - CAPACITY must be a power of two
module open_addressing_hash_table
  import oaht_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  req_t              req,
  output logic              busy,
  input  logic              cfg_we,
  input  logic [FILL_W-1:0] cfg_data,
  output logic              done,
  output rsp_t              rsp
);
  localparam int AW = $clog2(CAPACITY);

  logic [FILL_W-1:0] max_fill;
  logic q_valid, q_take;
  req_t q_req;
  logic [AW-1:0] q_idx;

  // max_fill register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_fill <= MAX_FILL_RST;
    end else if (cfg_we) begin
      max_fill <= cfg_data;
    end
  end

  // front queue stage
  oaht_front #(.CAPACITY(CAPACITY)) u_front (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy),
    .q_valid(q_valid), .q_req(q_req), .q_idx(q_idx), .q_take(q_take));

  // back probe engine
  oaht_back #(.CAPACITY(CAPACITY)) u_back (
    .clk(clk), .rst(rst), .max_fill(max_fill), .q_valid(q_valid), .q_req(q_req),
    .q_idx(q_idx), .q_take(q_take), .done(done), .rsp(rsp));
endmodule

[sim/open_addressing_hash_table_test.sv]
// self-checking testbench for open_addressing_hash_table: keeps its own copy of the
// slot table, predicts each get/set/delete and compares every done strobe in order
// depends on oaht_pkg and the open_addressing_hash_table rtl
`timescale 1ns / 1ps
module open_addressing_hash_table_test;
  import oaht_pkg::*;

  localparam int SLOTS = 256;
  localparam int POOL_SIZE = 320;
  localparam int STALL_LIMIT = 3000;
  localparam logic [1:0] MODE_UNKNOWN = 2'd3;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  req_t              cmd = '0;
  logic              busy;
  logic              cfg_we = 1'b0;
  logic [FILL_W-1:0] cfg_data = '0;
  logic              done;
  rsp_t              rsp;

  open_addressing_hash_table #(.CAPACITY(SLOTS)) dut (
    .clk(clk), .rst(rst), .start(start), .req(cmd), .busy(busy),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .rsp(rsp)
  );

  always #1 clk = ~clk;

  // shadow copy of the table
  logic [1:0]        shadow_state [SLOTS];
  logic [31:0]       shadow_key [SLOTS];
  logic [63:0]       shadow_val [SLOTS];
  int unsigned       shadow_fill;
  logic [FILL_W-1:0] shadow_max_fill;

  req_t        pending_cmds [$];
  rsp_t        expected_rsp [$];
  logic [31:0] pool_key [POOL_SIZE];
  logic [31:0] pool_hash [POOL_SIZE];
  int          errors = 0;
  int          checked = 0;
  int          status_seen [3] = '{0, 0, 0};
  int          gap_left = 0;
  bit          allow_gaps = 1'b1;
  int          quiet_cycles = 0;

  // probe and update the shadow table, return the expected response
  function automatic rsp_t apply_table_op(req_t r);
    rsp_t        o;
    int unsigned idx, hit_idx, empty_idx, tomb_idx;
    bit          hit, empty_found, tomb_found;
    o = '0;
    o.status = ST_MISSING;
    idx = r.key_hash % SLOTS;
    hit = 0; empty_found = 0; tomb_found = 0;
    hit_idx = 0; empty_idx = 0; tomb_idx = 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (shadow_state[idx] == SLOT_EMPTY) begin
        empty_found = 1;
        empty_idx = idx;
        break;
      end
      if (shadow_state[idx] == SLOT_TOMB) begin
        if (!tomb_found) begin
          tomb_found = 1;
          tomb_idx = idx;
        end
      end else if (shadow_key[idx] == r.key_id) begin
        hit = 1;
        hit_idx = idx;
        break;
      end
      idx = (idx + 1) % SLOTS;
    end
    case (r.mode)
      MODE_GET: begin
        if (hit) begin
          o.status = ST_DONE;
          o.value_out = shadow_val[hit_idx];
        end
      end
      MODE_SET: begin
        if (hit) begin
          shadow_val[hit_idx] = r.value_in;
          o.status = ST_DONE;
        end else if (tomb_found) begin
          // first tombstone on the probe path gets reused, fill unchanged
          shadow_state[tomb_idx] = SLOT_LIVE;
          shadow_key[tomb_idx] = r.key_id;
          shadow_val[tomb_idx] = r.value_in;
          o.status = ST_DONE;
          o.new_key = 1'b1;
        end else if (empty_found && shadow_fill < shadow_max_fill) begin
          shadow_state[empty_idx] = SLOT_LIVE;
          shadow_key[empty_idx] = r.key_id;
          shadow_val[empty_idx] = r.value_in;
          shadow_fill++;
          o.status = ST_DONE;
          o.new_key = 1'b1;
        end else begin
          o.status = ST_FULL;
        end
      end
      MODE_DEL: begin
        if (hit) begin
          shadow_state[hit_idx] = SLOT_TOMB;
          o.status = ST_DONE;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on result %0d: %s got %h expected %h", checked, what, got, want);
    errors++;
  endtask

  // driver: one transfer per accepting edge, random idle bursts
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_rsp.push_back(apply_table_op(cmd));
      if (start && busy) begin
        // hold the command until it is taken
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0 && allow_gaps && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 6);
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        start <= 1'b1;
        cmd <= pending_cmds.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("unexpected result status", 64'(rsp.status), 64'd0);
      end else begin
        rsp_t want;
        want = expected_rsp.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", 64'(rsp.status), 64'(want.status));
        if (rsp.new_key !== want.new_key)
          report_mismatch("new_key", 64'(rsp.new_key), 64'(want.new_key));
        if (rsp.value_out !== want.value_out)
          report_mismatch("value_out", rsp.value_out, want.value_out);
        if (want.status <= ST_FULL) status_seen[want.status]++;
      end
      checked++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  function automatic req_t make_cmd(logic [1:0] m, logic [31:0] k, logic [31:0] h,
                                    logic [63:0] v);
    req_t r;
    r.mode = m;
    r.key_id = k;
    r.key_hash = h;
    r.value_in = v;
    return r;
  endfunction

  function automatic req_t random_cmd();
    req_t        r;
    int unsigned p, sel;
    sel = $urandom_range(0, 99);
    r.mode = sel < 40 ? MODE_SET : sel < 70 ? MODE_GET : sel < 95 ? MODE_DEL : MODE_UNKNOWN;
    r.value_in = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 85) begin
      p = $urandom_range(0, POOL_SIZE - 1);
      r.key_id = pool_key[p];
      r.key_hash = pool_hash[p];
    end else begin
      r.key_id = $urandom;
      r.key_hash = $urandom;
    end
    return r;
  endfunction

  // sample away from the active edge so driver and monitor updates have settled
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || start || busy || expected_rsp.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_fill(logic [FILL_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    shadow_max_fill = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  logic [FILL_W-1:0] fill_plan [8] = '{9'd2, 9'd0, 9'd100, 9'd192, 9'd511, 9'd256, 9'd1, 9'd300};

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      shadow_state[i] = SLOT_EMPTY;
      shadow_key[i] = '0;
      shadow_val[i] = '0;
    end
    shadow_fill = 0;
    shadow_max_fill = MAX_FILL_RST;
    // pool keys: half clustered on start slots 0 to 31 to build long probe chains
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_key[i] = $urandom;
      pool_hash[i] = $urandom;
      if (i % 2 == 0) pool_hash[i][7:0] = 8'($urandom_range(0, 31));
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: collisions, wrap at the top slot, tombstone reuse, extremes
    pending_cmds.push_back(make_cmd(MODE_GET, 32'h0, 32'h0, '0));
    pending_cmds.push_back(make_cmd(MODE_SET, 32'h0, 32'h0, 64'h0));
    pending_cmds.push_back(make_cmd(MODE_GET, 32'h0, 32'h0, '1));
    pending_cmds.push_back(make_cmd(MODE_SET, 32'h0, 32'h0, '1));
    pending_cmds.push_back(make_cmd(MODE_SET, 32'hFFFF_FFFF, 32'h100, 64'h1234));
    pending_cmds.push_back(make_cmd(MODE_SET, 32'h11, 32'hFFFF_FFFF, 64'h5));
    pending_cmds.push_back(make_cmd(MODE_SET, 32'h22, 32'h0000_00FF, 64'h6));
    pending_cmds.push_back(make_cmd(MODE_GET, 32'h22, 32'h0000_00FF, '0));
    pending_cmds.push_back(make_cmd(MODE_GET, 32'hFFFF_FFFF, 32'h100, '0));
    pending_cmds.push_back(make_cmd(MODE_DEL, 32'hFFFF_FFFF, 32'h100, '0));
    pending_cmds.push_back(make_cmd(MODE_GET, 32'hFFFF_FFFF, 32'h100, '0));
    pending_cmds.push_back(make_cmd(MODE_DEL, 32'hFFFF_FFFF, 32'h100, '0));
    pending_cmds.push_back(make_cmd(MODE_GET, 32'h22, 32'h0000_00FF, '0));
    pending_cmds.push_back(make_cmd(MODE_SET, 32'h33, 32'h0, 64'hAAAA_5555_AAAA_5555));
    pending_cmds.push_back(make_cmd(MODE_GET, 32'h33, 32'h0, '0));
    pending_cmds.push_back(make_cmd(MODE_DEL, 32'h44, 32'h7, '0));
    pending_cmds.push_back(make_cmd(MODE_UNKNOWN, 32'h0, 32'h0, '1));
    pending_cmds.push_back(make_cmd(MODE_SET, 32'h55, 32'hFFFF_FF00, 64'h5555_AAAA_5555_AAAA));
    pending_cmds.push_back(make_cmd(MODE_GET, 32'h55, 32'hFFFF_FF00, '0));
    wait_idle();

    // random phases, each under a different fill limit
    for (int ph = 0; ph < 8; ph++) begin
      write_max_fill(fill_plan[ph]);
      if (ph == 7) allow_gaps = 1'b0;
      for (int i = 0; i < 240; i++) pending_cmds.push_back(random_cmd());
      wait_idle();
    end
    repeat (20) @(posedge clk);

    $display("checked %0d results: %0d done, %0d not found, %0d full; final fill %0d",
             checked, status_seen[0], status_seen[1], status_seen[2], shadow_fill);
    $display("fill limits 192, 2, 0, 100, 192, 511, 256, 1, 300 with %0d mismatches", errors);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[files.f]
hdl/oaht_pkg.sv
hdl/oaht_ram.sv
hdl/oaht_front.sv
hdl/oaht_back.sv
hdl/open_addressing_hash_table.sv
sim/open_addressing_hash_table_test.sv
